@@ rtl/linear_gradient_color_assert.svh @@
// ----------------------------------------------------------------------------
// Linear gradient color: assertion macros
// Concurrent check macros used by the top-level gradient RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LINEAR_GRADIENT_COLOR_ASSERT_SVH
`define LINEAR_GRADIENT_COLOR_ASSERT_SVH

`ifndef SYNTHESIS

`define LGC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("linear_gradient_color: assertion failed");

`define LGC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("linear_gradient_color: assertion failed");

`else

`define LGC_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define LGC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/lgc_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear gradient color package
// Widths, register indexes, mode and class codes, reciprocal constants.
// ----------------------------------------------------------------------------
package lgc_pkg;

   localparam int COORD_BITS  = 12;
   localparam int OFF_W       = COORD_BITS + 1;
   localparam int SPAN_W      = COORD_BITS + 1;
   localparam int PCT_W       = 7;
   localparam int MAG_W       = OFF_W + PCT_W;
   localparam int CH_W        = 8;
   localparam int COLOR_W     = 4 * CH_W;
   localparam int SUM_W       = CH_W + PCT_W;
   localparam int RECIP_W     = 13;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int RECIP_SHIFT = 19;
   localparam int DIV_STEPS_A = 3;
   localparam int DIV_STEPS_B = PCT_W - DIV_STEPS_A;

   localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_START = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_END   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN        = 3'd5;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_SOLID = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HORIZ = 2'd1;
   localparam logic [MODE_W-1:0] MODE_VERT  = 2'd2;

   localparam int CLS_W = 2;
   localparam logic [CLS_W-1:0] CLS_START = 2'd0;
   localparam logic [CLS_W-1:0] CLS_END   = 2'd1;
   localparam logic [CLS_W-1:0] CLS_BLEND = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [CLS_W-1:0] cls;
   } lgc_ctl_type;

endpackage

@@ rtl/lgc_blend.sv @@
// ----------------------------------------------------------------------------
// Linear gradient color: channel blend
// Weighted sum of start and end channel, then scaled by the reciprocal of 100.
// ----------------------------------------------------------------------------
module lgc_blend import lgc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  lgc_ctl_type       ctl,
   input  logic [PCT_W-1:0]  pct,
   input  logic [CH_W-1:0]   c_start,
   input  logic [CH_W-1:0]   c_end,
   output lgc_ctl_type       ctl_out,
   output logic [PROD_W-1:0] prod
);

   logic [PCT_W-1:0]  inv_pct;
   logic [SUM_W-1:0]  part_start;
   logic [SUM_W-1:0]  part_end;
   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  sum_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;
   lgc_ctl_type       ctl_sum_ff;
   lgc_ctl_type       ctl_prod_ff;

   assign inv_pct    = PCT_FULL - pct;
   assign part_start = SUM_W'(inv_pct) * SUM_W'(c_start);
   assign part_end   = SUM_W'(pct) * SUM_W'(c_end);
   assign sum_in     = part_start + part_end;
   assign prod_in    = PROD_W'(sum_ff) * PROD_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff          <= sum_in;
         prod_ff         <= prod_in;
         ctl_sum_ff.cls  <= ctl.cls;
         ctl_prod_ff.cls <= ctl_sum_ff.cls;
      end
      if (reset) begin
         ctl_sum_ff.valid  <= 1'b0;
         ctl_prod_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_sum_ff.valid  <= ctl.valid;
         ctl_prod_ff.valid <= ctl_sum_ff.valid;
      end
   end

   assign prod    = prod_ff;
   assign ctl_out = ctl_prod_ff;

endmodule

@@ rtl/linear_gradient_color.sv @@
// ----------------------------------------------------------------------------
// Linear gradient color
// Fill color of one pixel under a solid, horizontal or vertical ARGB gradient.
// ----------------------------------------------------------------------------
// Usage:
//   Configure through the csr_ write port while the block is idle: fill mode,
//   start and end color, gradient origin and signed span.
//   Send pixel coordinates as req_ beats (req_valid, req_stall). Each beat
//   yields one rsp_ beat carrying red, green, blue and alpha, in order.
//   Throughput: one beat per cycle while rsp_stall does not hold a valid
//   result, set by the seven-stage pipeline (offset, scale by 100, two
//   divide stages, weighted sum, reciprocal multiply, output select), all
//   stages advancing together.
//   The percentage comes from a 7-bit restoring divide split over two stages.
//   Reset (synchronous, active high) empties the pipeline and loads the
//   register defaults: solid mode, black colors, origin 0, span 1.
//   req_stall stays high while reset is asserted.
//   When rsp_stall holds a valid result, the whole pipeline freezes and
//   req_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "linear_gradient_color_assert.svh"

module linear_gradient_color import lgc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_W-1:0]       rsp_red,
   output logic [CH_W-1:0]       rsp_green,
   output logic [CH_W-1:0]       rsp_blue,
   output logic [CH_W-1:0]       rsp_alpha
);

   logic [MODE_W-1:0]     fill_mode_ff;
   logic [COLOR_W-1:0]    color_start_ff;
   logic [COLOR_W-1:0]    color_end_ff;
   logic [COORD_BITS-1:0] origin_x_ff;
   logic [COORD_BITS-1:0] origin_y_ff;
   logic [SPAN_W-1:0]     span_ff;
   logic [SPAN_W-1:0]     span_mag_ff;
   logic [MAG_W-1:0]      span100_ff;

   logic adv;

   logic [COORD_BITS-1:0] sel_px;
   logic [COORD_BITS-1:0] sel_org;
   logic [OFF_W-1:0]      off_in;
   logic                  solid_in;
   logic [OFF_W-1:0]      off_s1_ff;
   logic                  solid_s1_ff;
   logic                  valid_s1_ff;

   logic [OFF_W-1:0] abs_off;
   logic [MAG_W-1:0] mag_in;
   logic [MAG_W-1:0] mag_s2_ff;
   logic             start_s2_ff;
   logic             valid_s2_ff;

   logic [CLS_W-1:0] cls_in;
   logic [MAG_W-1:0] rem_a;
   logic [PCT_W-1:0] q_a;
   logic [MAG_W-1:0] trial_a;
   logic [MAG_W-1:0] rem_s3_ff;
   logic [PCT_W-1:0] q_s3_ff;
   lgc_ctl_type      ctl_s3_ff;

   logic [MAG_W-1:0] rem_b;
   logic [PCT_W-1:0] q_b;
   logic [MAG_W-1:0] trial_b;
   logic [PCT_W-1:0] pct_s4_ff;
   lgc_ctl_type      ctl_s4_ff;

   lgc_ctl_type       ctl_ch [4];
   logic [PROD_W-1:0] prod_ch [4];
   logic [CH_W-1:0]   mix_ch [4];
   logic [CH_W-1:0]   out_ch_in [4];

   logic            rsp_valid_ff;
   logic [CH_W-1:0] rsp_red_ff;
   logic [CH_W-1:0] rsp_green_ff;
   logic [CH_W-1:0] rsp_blue_ff;
   logic [CH_W-1:0] rsp_alpha_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_mode_ff   <= MODE_SOLID;
         color_start_ff <= '0;
         color_end_ff   <= '0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         span_ff        <= SPAN_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FILL_MODE:   fill_mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_COLOR_START: color_start_ff <= csr_wdata[COLOR_W-1:0];
            CSR_COLOR_END:   color_end_ff   <= csr_wdata[COLOR_W-1:0];
            CSR_ORIGIN_X:    origin_x_ff    <= csr_wdata[COORD_BITS-1:0];
            CSR_ORIGIN_Y:    origin_y_ff    <= csr_wdata[COORD_BITS-1:0];
            CSR_SPAN:        span_ff        <= csr_wdata[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   // span magnitude and its hundredfold, derived from static configuration
   always_ff @(posedge clock) begin
      span_mag_ff <= span_ff[SPAN_W-1] ? (SPAN_W'(0) - span_ff) : span_ff;
      span100_ff  <= MAG_W'(span_mag_ff) * MAG_W'(PCT_FULL);
   end

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || reset;

   // stage 1: offset from origin along the chosen axis
   assign sel_px   = (fill_mode_ff == MODE_HORIZ) ? req_pixel_x : req_pixel_y;
   assign sel_org  = (fill_mode_ff == MODE_HORIZ) ? origin_x_ff : origin_y_ff;
   assign off_in   = {sel_px[COORD_BITS-1], sel_px} - {sel_org[COORD_BITS-1], sel_org};
   assign solid_in = !((fill_mode_ff == MODE_HORIZ) || (fill_mode_ff == MODE_VERT))
                     || (span_ff == '0);

   // stage 2: magnitude times 100, early start-color decision
   assign abs_off = off_s1_ff[OFF_W-1] ? (OFF_W'(0) - off_s1_ff) : off_s1_ff;
   assign mag_in  = MAG_W'(abs_off) * MAG_W'(PCT_FULL);

   // stage 3: classify, upper quotient bits
   always_comb begin
      if (start_s2_ff || (mag_s2_ff < MAG_W'(span_mag_ff))) begin
         cls_in = CLS_START;
      end else if (mag_s2_ff >= span100_ff) begin
         cls_in = CLS_END;
      end else begin
         cls_in = CLS_BLEND;
      end
      rem_a   = mag_s2_ff;
      q_a     = '0;
      trial_a = '0;
      for (int k = 0; k < DIV_STEPS_A; k++) begin
         trial_a = MAG_W'(span_mag_ff) << (PCT_W - 1 - k);
         if (rem_a >= trial_a) begin
            rem_a             = rem_a - trial_a;
            q_a[PCT_W-1-k]    = 1'b1;
         end
      end
   end

   // stage 4: lower quotient bits
   always_comb begin
      rem_b   = rem_s3_ff;
      q_b     = q_s3_ff;
      trial_b = '0;
      for (int k = 0; k < DIV_STEPS_B; k++) begin
         trial_b = MAG_W'(span_mag_ff) << (DIV_STEPS_B - 1 - k);
         if (rem_b >= trial_b) begin
            rem_b                   = rem_b - trial_b;
            q_b[DIV_STEPS_B-1-k]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         off_s1_ff   <= off_in;
         solid_s1_ff <= solid_in;
         mag_s2_ff   <= mag_in;
         start_s2_ff <= solid_s1_ff || (off_s1_ff == '0)
                        || (off_s1_ff[OFF_W-1] != span_ff[SPAN_W-1]);
         rem_s3_ff   <= rem_a;
         q_s3_ff     <= q_a;
         ctl_s3_ff.cls <= cls_in;
         pct_s4_ff   <= q_b;
         ctl_s4_ff.cls <= ctl_s3_ff.cls;
      end
      if (reset) begin
         valid_s1_ff     <= 1'b0;
         valid_s2_ff     <= 1'b0;
         ctl_s3_ff.valid <= 1'b0;
         ctl_s4_ff.valid <= 1'b0;
      end else if (adv) begin
         valid_s1_ff     <= req_valid;
         valid_s2_ff     <= valid_s1_ff;
         ctl_s3_ff.valid <= valid_s2_ff;
         ctl_s4_ff.valid <= ctl_s3_ff.valid;
      end
   end

   // stages 5 and 6: per-channel blend; channel 0 red, 1 green, 2 blue, 3 alpha
   for (genvar ch = 0; ch < 4; ch++) begin : g_ch
      localparam int SH = (ch == 3) ? 3 * CH_W : (2 - ch) * CH_W;

      lgc_blend u_blend (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .ctl     (ctl_s4_ff),
         .pct     (pct_s4_ff),
         .c_start (color_start_ff[SH +: CH_W]),
         .c_end   (color_end_ff[SH +: CH_W]),
         .ctl_out (ctl_ch[ch]),
         .prod    (prod_ch[ch])
      );

      assign mix_ch[ch] = prod_ch[ch][RECIP_SHIFT +: CH_W];

      always_comb begin
         case (ctl_ch[0].cls)
            CLS_START: out_ch_in[ch] = color_start_ff[SH +: CH_W];
            CLS_END:   out_ch_in[ch] = color_end_ff[SH +: CH_W];
            default:   out_ch_in[ch] = mix_ch[ch];
         endcase
      end
   end

   // stage 7: output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_ch[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_ff   <= out_ch_in[0];
         rsp_green_ff <= out_ch_in[1];
         rsp_blue_ff  <= out_ch_in[2];
         rsp_alpha_ff <= out_ch_in[3];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;
   assign rsp_alpha = rsp_alpha_ff;

   `LGC_ASSERT_IMPLY(a_blend_pct_range, clock, reset,
      ctl_s4_ff.valid && (ctl_s4_ff.cls == CLS_BLEND),
      (pct_s4_ff != '0) && (pct_s4_ff < PCT_FULL))
   `LGC_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset,
      !rsp_valid_ff && !valid_s1_ff && !ctl_s4_ff.valid)
   `LGC_ASSERT_NEXT(a_freeze_holds, clock, reset, !adv,
      $stable(ctl_s4_ff) && $stable(pct_s4_ff) && $stable(valid_s2_ff))
   `LGC_ASSERT_IMPLY(a_start_below_one, clock, reset,
      valid_s2_ff && !start_s2_ff && (mag_s2_ff < MAG_W'(span_mag_ff)),
      cls_in == CLS_START)

endmodule
